// File: hw/rtl/lkct_pkg.sv
// Shared types and constants for the LRU key cache tracker.
// No dependencies; every other file of the block imports this package.
package lkct_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_W    = 32;
	localparam int SIZE_W   = 5;
	localparam int OCC_W    = 5;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
	localparam int OUT_W    = 2 + KEY_W + OCC_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

	localparam logic CMD_PROBE  = 1'b0;
	localparam logic CMD_ACCESS = 1'b1;

	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		logic valid;
		logic shift;
		logic load;
	} cell_ctrl_t;

endpackage

// File: hw/rtl/lkct_cell.sv
// One slot of the ordered key list: holds a key, compares it to the request key
// and takes either the newer neighbor's key or the request key. Uses lkct_pkg.
module lkct_cell import lkct_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  key_t       next_key,
	input  key_t       req_key,
	output key_t       key,
	output logic       match
);

	key_t key_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			key_q <= req_key;
		end else if (ctrl.shift) begin
			key_q <= next_key;
		end
	end

	assign key   = key_q;
	assign match = ctrl.valid && (key_q == req_key);

endmodule

// File: hw/rtl/lru_key_cache_tracker_unit.sv
// Top level of the LRU key cache tracker: a row of lkct_cell slots, oldest first,
// plus count, limit register and the output register. Uses lkct_pkg, lkct_cell.
//
// channel  dir  handshake                     payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tuser: cmd, tdata: key
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata: hit, evicted_valid, evicted_key, occupancy
// cfg      in   cfg_valid/cfg_ready           cfg_data: active_size
//
// One request per cycle while the output is not stalled: all slots compare in parallel and shift
// toward the oldest in the same cycle the request is taken; the result is registered for the next cycle.
// A new request is taken while the output register is empty or being drained.
// Reset empties the list and sets active_size to 16; no clearing pass is needed.
// cfg_ready is always high.
module lru_key_cache_tracker_unit import lkct_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [KEY_W-1:0]       s_axis_tdata,  // [31:0] key
	input  logic                   s_axis_tuser,  // [0] cmd
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [0] hit, [1] evicted_valid,
	                                              // [33:2] evicted_key, [38:34] occupancy
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [SIZE_W-1:0]      cfg_data       // [4:0] active_size
);

	logic [SIZE_W-1:0]      active_q;
	logic [CNT_W-1:0]       count_q;
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	cell_ctrl_t          ctrl [CAPACITY];
	key_t                cell_key [CAPACITY];
	logic [CAPACITY-1:0] match;
	logic [CAPACITY-1:0] at_or_after;

	logic             in_fire;
	logic             access;
	logic             hit;
	logic             full;
	logic             evict;
	logic             grow;
	logic [CNT_W-1:0] load_pos;
	logic [CNT_W-1:0] count_next;
	logic             seen;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign access        = (s_axis_tuser == CMD_ACCESS);
	assign hit           = |match;

	// limit of zero acts as one, limit above capacity acts as capacity
	assign full = (count_q != '0) &&
		((CMP_W'(count_q) >= CMP_W'(active_q)) || (CMP_W'(count_q) >= CMP_W'(CAPACITY)));
	assign evict    = access && !hit && full;
	assign grow     = access && !hit && !full;
	assign load_pos = (hit || full) ? count_q - CNT_W'(1) : count_q;
	assign count_next = grow ? count_q + CNT_W'(1) : count_q;

	// mark slots at or past the hit position; they close the gap
	always_comb begin
		seen = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			seen           = seen | match[i];
			at_or_after[i] = seen;
		end
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			ctrl[i].valid = CNT_W'(i) < count_q;
			ctrl[i].shift = in_fire && access && (hit ? at_or_after[i] : evict) &&
				(CNT_W'(i) < load_pos);
			ctrl[i].load  = in_fire && access && (CNT_W'(i) == load_pos);
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		key_t next_key;
		if (g == CAPACITY - 1) begin : g_tail
			assign next_key = '0;
		end else begin : g_link
			assign next_key = cell_key[g+1];
		end
		lkct_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl[g]),
			.next_key (next_key),
			.req_key  (s_axis_tdata),
			.key      (cell_key[g]),
			.match    (match[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= SIZE_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				active_q <= cfg_data;
			end
			if (in_fire) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data_q <= OUT_TDATA_W'({
				OCC_W'(count_next),
				evict ? cell_key[0] : key_t'(0),
				evict,
				hit
			});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// File: hw/rtl/lkct_checker.sv
// Port-level checks for the LRU key cache tracker, bound to the top level.
// Uses lkct_pkg for the result layout and capacity.
module lkct_checker import lkct_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic             r_hit;
	logic             r_ev_valid;
	logic [KEY_W-1:0] r_ev_key;
	logic [OCC_W-1:0] r_occ;

	assign r_hit      = m_axis_tdata[0];
	assign r_ev_valid = m_axis_tdata[1];
	assign r_ev_key   = m_axis_tdata[KEY_W+1:2];
	assign r_occ      = m_axis_tdata[KEY_W+OCC_W+1:KEY_W+2];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(r_hit && r_ev_valid))
		else $error("eviction reported on a hit");

	a_ev_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !r_ev_valid |-> r_ev_key == '0)
		else $error("evicted key nonzero without eviction");

	a_evict_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (r_ev_valid || r_hit) |-> r_occ != '0)
		else $error("empty list after hit or eviction");

	a_occ_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> 32'(r_occ) <= 32'(CAPACITY))
		else $error("occupancy above capacity");

endmodule

bind lru_key_cache_tracker_unit lkct_checker u_lkct_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: verif/tb_lru_key_cache_tracker_unit.sv
// Self-checking testbench for lru_key_cache_tracker_unit: directed and random
// probe/access requests under sender bursts and receiver stalls. Uses lkct_pkg.
module tb_lru_key_cache_tracker_unit;
	import lkct_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 85;

	typedef struct packed {
		logic             hit;
		logic             evicted_valid;
		key_t             evicted_key;
		logic [OCC_W-1:0] occupancy;
	} lru_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [KEY_W-1:0]       s_axis_tdata = '0;  // [31:0] key
	logic                   s_axis_tuser = 1'b0;  // [0] cmd
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;  // [0] hit, [1] evicted_valid,
	                                       // [33:2] evicted_key, [38:34] occupancy
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [SIZE_W-1:0]      cfg_data = '0;  // [4:0] active_size

	// mirror of the tracker: oldest key at index 0
	key_t              lru_keys[$];
	logic [SIZE_W-1:0] size_limit = SIZE_RESET;
	lru_result_t       pending_results[$];
	key_t              key_pool[$];

	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	logic [5:0]  stall_phase = '0;
	logic [1:0]  stall_mode = '0;
	logic [15:0] stall_pattern = 16'hFFFF;

	lru_key_cache_tracker_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int effective_limit(logic [SIZE_W-1:0] size);
		if (size == 0)
			return 1;
		if (size > CAPACITY)
			return CAPACITY;
		return int'(size);
	endfunction

	function automatic lru_result_t track_request(logic cmd, key_t key);
		lru_result_t r;
		int pos;
		r = '0;
		pos = -1;
		foreach (lru_keys[i]) begin
			if (pos < 0 && lru_keys[i] == key)
				pos = i;
		end
		r.hit = (pos >= 0);
		if (cmd == CMD_ACCESS) begin
			if (pos >= 0) begin
				lru_keys.delete(pos);
			end else if (lru_keys.size() >= effective_limit(size_limit) && lru_keys.size() > 0) begin
				r.evicted_valid = 1'b1;
				r.evicted_key   = lru_keys.pop_front();
			end
			if (lru_keys.size() < CAPACITY)
				lru_keys = {lru_keys, key};
		end
		r.occupancy = OCC_W'(lru_keys.size());
		return r;
	endfunction

	function automatic key_t pick_key();
		if (key_pool.size() == 0 || $urandom_range(0, 4) == 0)
			return $urandom;
		return key_pool[$urandom_range(0, key_pool.size() - 1)];
	endfunction

	// Send one request, then keep the burst going or open a gap.
	task automatic send_request(logic cmd, key_t key);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= key;
		do @(posedge clk); while (!s_axis_tready);
		pending_results = {pending_results, track_request(cmd, key)};
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 19);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Write active_size only once the pipeline has drained.
	task automatic set_active_size(logic [SIZE_W-1:0] size);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= size;
		do @(posedge clk); while (!cfg_ready);
		size_limit = size;
		cfg_valid <= 1'b0;
	endtask

	task automatic test_probe_and_hit();
		send_request(CMD_PROBE,  32'h0000_0000);
		send_request(CMD_ACCESS, 32'h0000_0000);
		send_request(CMD_ACCESS, 32'hFFFF_FFFF);
		send_request(CMD_PROBE,  32'hFFFF_FFFF);
		send_request(CMD_ACCESS, 32'h0000_0000);
		send_request(CMD_ACCESS, 32'h1234_5678);
		send_request(CMD_PROBE,  32'hA5A5_5A5A);
	endtask

	// Zero acts as one; the list is already above the limit, so misses evict one key each.
	task automatic test_limit_zero();
		set_active_size('0);
		send_request(CMD_ACCESS, 32'h0000_0001);
		send_request(CMD_ACCESS, 32'h0000_0000);
		send_request(CMD_PROBE,  32'hFFFF_FFFF);
		send_request(CMD_ACCESS, 32'h8000_0000);
	endtask

	task automatic test_limit_above_capacity();
		set_active_size(5'd31);
		send_request(CMD_ACCESS, 32'h5A5A_A5A5);
		send_request(CMD_ACCESS, 32'h0000_0001);
		send_request(CMD_ACCESS, 32'h7FFF_FFFF);
		send_request(CMD_PROBE,  32'h8000_0000);
	endtask

	task automatic test_random_traffic();
		logic [SIZE_W-1:0] sizes[10];
		int pool_size;
		sizes = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd8, 5'd17, 5'd2, 5'd12, 5'd16};
		sizes[9] = $urandom_range(0, 31);
		foreach (sizes[p]) begin
			set_active_size(sizes[p]);
			// a pool slightly larger than the limit mixes hits with evictions
			key_pool.delete();
			pool_size = effective_limit(sizes[p]) + $urandom_range(1, 4);
			repeat (pool_size) key_pool = {key_pool, key_t'($urandom)};
			repeat (PHASE_ITEMS)
				send_request(($urandom_range(0, 3) == 0) ? CMD_PROBE : CMD_ACCESS, pick_key());
		end
		s_axis_tvalid <= 1'b0;
	endtask

	// Receiver: per stall_phase wrap, always-ready, random stalls or a rotating pattern.
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1'b1;
		if (stall_phase == '0) begin
			stall_mode    <= 2'($urandom_range(0, 3));
			stall_pattern <= 16'($urandom) | 16'h0101;
		end
		case (stall_mode)
			2'd0: m_axis_tready <= 1'b1;
			2'd1: m_axis_tready <= stall_pattern[stall_phase[3:0]];
			2'd2: m_axis_tready <= ($urandom_range(0, 3) != 0);
			default: m_axis_tready <= stall_pattern[stall_phase[3:0]] | stall_phase[0];
		endcase
	end

	task automatic check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		lru_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result expected none actual %h", $time, m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				check_field("hit", KEY_W'(want.hit), KEY_W'(m_axis_tdata[0]));
				check_field("evicted_valid", KEY_W'(want.evicted_valid), KEY_W'(m_axis_tdata[1]));
				check_field("evicted_key", want.evicted_key, m_axis_tdata[33:2]);
				check_field("occupancy", KEY_W'(want.occupancy), KEY_W'(m_axis_tdata[38:34]));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_probe_and_hit();
		test_limit_zero();
		test_limit_above_capacity();
		test_random_traffic();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
